FILE: rtl/mmx_pkg.sv
// ----------------------------------------------------------------------------
// mmx_pkg: shared types and constants for the 4x4 matrix multiplier
// Field widths, op codes and the command/status structs between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package mmx_pkg;

    // Default matrix order
    localparam int MATRIX_DIM_DEF = 4;

    // Fixed field widths
    localparam int OP_W    = 2;
    localparam int INDEX_W = 4;
    localparam int DATA_W  = 32;
    localparam int FRAC_W  = 16;

    // Op codes of an input transaction
    localparam logic [OP_W-1:0] OP_LOAD_L  = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_R  = 2'd1;
    localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

    // Commands from controller to datapath
    typedef struct packed {
        logic               wr_l;       // write left store
        logic               wr_r;       // write right store
        logic               rd_en;      // issue one operand pair read
        logic               k_first;    // first term of a dot product
        logic               k_last;     // last term of a dot product
        logic               out_load;   // load the result register
        logic               out_last;   // final product element
        logic [INDEX_W-1:0] out_index;  // column-major index of the element
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic acc_done;  // accumulator holds a finished dot product
        logic out_free;  // result register can take a new element
    } t_stat;

endpackage

FILE: rtl/mmx_in_if.sv
// ----------------------------------------------------------------------------
// mmx_in_if: input channel of the matrix multiplier
// Valid/ready channel carrying one load or compute request.
// ----------------------------------------------------------------------------
interface mmx_in_if import mmx_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          op;
    logic [INDEX_W-1:0]       elem_index;
    logic signed [DATA_W-1:0] elem_value;

    modport source (output valid, output op, output elem_index, output elem_value,
                    input ready);
    modport sink   (input valid, input op, input elem_index, input elem_value,
                    output ready);

endinterface

FILE: rtl/mmx_out_if.sv
// ----------------------------------------------------------------------------
// mmx_out_if: output channel of the matrix multiplier
// Valid/ready channel carrying one product element.
// ----------------------------------------------------------------------------
interface mmx_out_if import mmx_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic [INDEX_W-1:0]       out_index;
    logic signed [DATA_W-1:0] out_value;
    logic                     last;

    modport source (output valid, output out_index, output out_value, output last,
                    input ready);
    modport sink   (input valid, input out_index, input out_value, input last,
                    output ready);

endinterface

FILE: rtl/matrix_multiply_4x4.sv
// ----------------------------------------------------------------------------
// matrix_multiply_4x4: column-major square matrix product in Q16.16
// Loads left and right elements one transaction at a time; a compute request
// streams the product elements in column-major order, last one marked.
// ----------------------------------------------------------------------------
//  Port     Dir   Transaction
//  i_cmd    in    op, elem_index, elem_value (load left, load right, compute)
//  o_res    out   out_index, out_value, last (one product element)
//
//  A load is written into its store in the cycle it is accepted. For each product
//  element a compute request issues one store read per term, then multiplies,
//  accumulates and rounds, and waits out any output stall before the next element
//  starts. A single multiply-accumulate unit serves every element.
//  i_cmd is not ready while a product is being computed; a stalled o_res
//  holds the sequencer before the next element is loaded into the result
//  register. Reset clears the store valid bits at once; no clearing pass.
// ----------------------------------------------------------------------------
module matrix_multiply_4x4 import mmx_pkg::*; #(
    parameter int MATRIX_DIM = MATRIX_DIM_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mmx_in_if.sink     i_cmd,
    mmx_out_if.source  o_res
);

    localparam int ADDR_W = $clog2(MATRIX_DIM * MATRIX_DIM);

    t_cmd              w_cmd;
    t_stat             w_stat;
    logic [ADDR_W-1:0] w_rd_addr_l;
    logic [ADDR_W-1:0] w_rd_addr_r;

    // Sequence the transactions
    mmx_ctrl #(
        .MATRIX_DIM (MATRIX_DIM)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .i_in_op     (i_cmd.op),
        .o_in_ready  (i_cmd.ready),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat),
        .o_rd_addr_l (w_rd_addr_l),
        .o_rd_addr_r (w_rd_addr_r)
    );

    // Store, multiply, accumulate, round
    mmx_dp #(
        .MATRIX_DIM (MATRIX_DIM)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_elem_index (i_cmd.elem_index),
        .i_elem_value (i_cmd.elem_value),
        .i_rd_addr_l  (w_rd_addr_l),
        .i_rd_addr_r  (w_rd_addr_r),
        .o_out_valid  (o_res.valid),
        .i_out_ready  (o_res.ready),
        .o_out_index  (o_res.out_index),
        .o_out_value  (o_res.out_value),
        .o_out_last   (o_res.last)
    );

endmodule

FILE: rtl/mmx_ctrl.sv
// ----------------------------------------------------------------------------
// mmx_ctrl: sequencer of the matrix multiplier
// Decodes input transactions, walks the product elements in column-major
// order and issues one operand read per term of each dot product.
// ----------------------------------------------------------------------------
module mmx_ctrl import mmx_pkg::*; #(
    parameter int MATRIX_DIM = MATRIX_DIM_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    input  logic [OP_W-1:0]                         i_in_op,
    output logic                                    o_in_ready,
    output t_cmd                                    o_cmd,
    input  t_stat                                   i_stat,
    output logic [$clog2(MATRIX_DIM*MATRIX_DIM)-1:0] o_rd_addr_l,
    output logic [$clog2(MATRIX_DIM*MATRIX_DIM)-1:0] o_rd_addr_r
);

    localparam int IDX_W  = $clog2(MATRIX_DIM);
    localparam int ADDR_W = $clog2(MATRIX_DIM * MATRIX_DIM);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MATRIX_DIM - 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ISSUE = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [IDX_W-1:0] r_k, n_k;
    logic [IDX_W-1:0] r_row, n_row;
    logic [IDX_W-1:0] r_col, n_col;
    logic             w_accept;
    logic             w_cell_last;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_cell_last = (r_row == LAST_IDX) && (r_col == LAST_IDX);

    // Operand addresses: left(row, k) and right(k, col)
    assign o_rd_addr_l = ADDR_W'(32'(r_k) * MATRIX_DIM + 32'(r_row));
    assign o_rd_addr_r = ADDR_W'(32'(r_col) * MATRIX_DIM + 32'(r_k));

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_row   = r_row;
        n_col   = r_col;
        o_cmd   = '0;
        o_cmd.out_index = INDEX_W'(32'(r_col) * MATRIX_DIM + 32'(r_row));
        o_cmd.out_last  = w_cell_last;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_in_op)
                        OP_LOAD_L: o_cmd.wr_l = 1'b1;
                        OP_LOAD_R: o_cmd.wr_r = 1'b1;
                        OP_COMPUTE: begin
                            n_k     = '0;
                            n_row   = '0;
                            n_col   = '0;
                            n_state = S_ISSUE;
                        end
                        default: ;
                    endcase
                end
            end
            S_ISSUE: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.k_first = (r_k == '0);
                o_cmd.k_last  = (r_k == LAST_IDX);
                if (r_k == LAST_IDX) begin
                    n_k     = '0;
                    n_state = S_DRAIN;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_DRAIN: begin
                if (i_stat.acc_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (w_cell_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_ISSUE;
                        if (r_row == LAST_IDX) begin
                            n_row = '0;
                            n_col = r_col + 1'b1;
                        end else begin
                            n_row = r_row + 1'b1;
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_row   <= '0;
            r_col   <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_row   <= n_row;
            r_col   <= n_col;
        end
    end

endmodule

FILE: rtl/mmx_dp.sv
// ----------------------------------------------------------------------------
// mmx_dp: datapath of the matrix multiplier
// Element stores, multiply-accumulate pipeline, rounding with saturation
// and the result register.
// ----------------------------------------------------------------------------
module mmx_dp import mmx_pkg::*; #(
    parameter int MATRIX_DIM = MATRIX_DIM_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  t_cmd                                    i_cmd,
    output t_stat                                   o_stat,
    input  logic [INDEX_W-1:0]                      i_elem_index,
    input  logic signed [DATA_W-1:0]                i_elem_value,
    input  logic [$clog2(MATRIX_DIM*MATRIX_DIM)-1:0] i_rd_addr_l,
    input  logic [$clog2(MATRIX_DIM*MATRIX_DIM)-1:0] i_rd_addr_r,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic [INDEX_W-1:0]                      o_out_index,
    output logic signed [DATA_W-1:0]                o_out_value,
    output logic                                    o_out_last
);

    localparam int CELLS  = MATRIX_DIM * MATRIX_DIM;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int PROD_W = 2 * DATA_W;
    localparam int ACC_W  = PROD_W + $clog2(MATRIX_DIM);
    localparam int HALF   = 1 << (FRAC_W - 1);

    // Stores; entries not yet written read as zero through the valid bits
    logic [DATA_W-1:0]        mem_l [CELLS];
    logic [DATA_W-1:0]        mem_r [CELLS];
    logic [CELLS-1:0]         r_vld_l;
    logic [CELLS-1:0]         r_vld_r;

    logic                     w_in_range;
    logic [ADDR_W-1:0]        w_waddr;

    logic [DATA_W-1:0]        r_a_raw, r_b_raw;
    logic                     r_a_ok, r_b_ok;
    logic signed [DATA_W-1:0] w_a, w_b;

    logic                     r_s1_v, r_s1_first, r_s1_last;
    logic                     r_s2_v, r_s2_first, r_s2_last;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_done;

    logic signed [ACC_W-1:0]  w_rnd;
    logic signed [ACC_W-1:0]  w_shift;
    logic                     w_fits;
    logic signed [DATA_W-1:0] w_sat;

    logic                     r_out_valid;
    logic [INDEX_W-1:0]       r_out_index;
    logic [DATA_W-1:0]        r_out_value;
    logic                     r_out_last;

    assign w_in_range = (32'(i_elem_index) < 32'(CELLS));
    assign w_waddr    = ADDR_W'(i_elem_index);

    // Write and read the stores
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_l && w_in_range) begin
            mem_l[w_waddr] <= i_elem_value;
        end
        if (i_cmd.wr_r && w_in_range) begin
            mem_r[w_waddr] <= i_elem_value;
        end
        r_a_raw <= mem_l[i_rd_addr_l];
        r_b_raw <= mem_r[i_rd_addr_r];
        r_a_ok  <= r_vld_l[i_rd_addr_l];
        r_b_ok  <= r_vld_r[i_rd_addr_r];
    end

    // Mark written entries
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_l <= '0;
            r_vld_r <= '0;
        end else begin
            if (i_cmd.wr_l && w_in_range) begin
                r_vld_l[w_waddr] <= 1'b1;
            end
            if (i_cmd.wr_r && w_in_range) begin
                r_vld_r[w_waddr] <= 1'b1;
            end
        end
    end

    assign w_a = r_a_ok ? $signed(r_a_raw) : '0;
    assign w_b = r_b_ok ? $signed(r_b_raw) : '0;

    // Advance term tags alongside the operands
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_s1_v <= i_cmd.rd_en;
            r_s2_v <= r_s1_v;
            r_done <= r_s2_v && r_s2_last;
        end
    end

    // Multiply, then accumulate at full precision
    always_ff @(posedge i_clk) begin
        r_s1_first <= i_cmd.k_first;
        r_s1_last  <= i_cmd.k_last;
        r_s2_first <= r_s1_first;
        r_s2_last  <= r_s1_last;
        r_prod     <= PROD_W'(w_a * w_b);
        if (r_s2_v) begin
            if (r_s2_first) begin
                r_acc <= ACC_W'(r_prod);
            end else begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
        end
    end

    // Round half up to Q16.16 and saturate
    assign w_rnd   = r_acc + $signed(ACC_W'(HALF));
    assign w_shift = w_rnd >>> FRAC_W;
    assign w_fits  = (&w_shift[ACC_W-1:DATA_W-1]) || !(|w_shift[ACC_W-1:DATA_W-1]);
    assign w_sat   = w_fits ? w_shift[DATA_W-1:0]
                   : (w_shift[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                       : {1'b0, {(DATA_W-1){1'b1}}});

    // Hold the result until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_index <= i_cmd.out_index;
            r_out_value <= w_sat;
            r_out_last  <= i_cmd.out_last;
        end
    end

    assign o_stat.acc_done = r_done;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_index = r_out_index;
    assign o_out_value = $signed(r_out_value);
    assign o_out_last  = r_out_last;

endmodule

FILE: test/matrix_multiply_4x4_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_multiply_4x4_tb: self-checking bench for the Q16.16 matrix multiplier
// Drives load and compute transactions through the command channel, keeps a
// shadow copy of both stores, computes each product element at full precision
// with half-up rounding and saturation, and checks every output transaction
// in order. Covers reset contents, saturation, rounding, unused op codes and
// random traffic under three sender/receiver idle mixes.
// ----------------------------------------------------------------------------
module matrix_multiply_4x4_tb;
    import mmx_pkg::*;

    localparam int DIM   = MATRIX_DIM_DEF;
    localparam int CELLS = DIM * DIM;

    // Op code the block must ignore
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam logic signed [DATA_W-1:0] Q_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q_MIN  = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] Q_ONE  = 32'sh0001_0000;
    localparam logic signed [DATA_W-1:0] Q_HALF = 32'sh0000_8000;

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [INDEX_W-1:0]       index;
        logic signed [DATA_W-1:0] value;
        logic                     is_last;
    } t_product_elem;

    logic i_clk;
    logic i_rst_n;

    mmx_in_if  cmd_if();
    mmx_out_if res_if();

    matrix_multiply_4x4 #(
        .MATRIX_DIM(DIM)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_if),
        .o_res  (res_if)
    );

    // Shadow stores and pending product elements
    logic signed [DATA_W-1:0] left_cells  [CELLS];
    logic signed [DATA_W-1:0] right_cells [CELLS];
    t_product_elem            pending_products[$];

    int send_idle_pct;
    int recv_idle_pct;
    int loads_seen;
    int computes_seen;
    int ignored_seen;
    int products_checked;
    int mismatch_count;

    // Clock generation
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs
    initial begin
        #8_000_000;
        $display("Timeout waiting for product elements");
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Product element at (row, col): exact sum, round half up, saturate
    function automatic logic signed [DATA_W-1:0] dot_product(int row, int col);
        logic signed [65:0] acc;
        logic signed [65:0] rounded;
        acc = '0;
        for (int k = 0; k < DIM; k++) begin
            acc = acc + left_cells[k * DIM + row] * right_cells[col * DIM + k];
        end
        rounded = (acc + 66'sd32768) >>> FRAC_W;
        if (rounded > 66'sd2147483647) begin
            return Q_MAX;
        end
        if (rounded < -66'sd2147483648) begin
            return Q_MIN;
        end
        return rounded[DATA_W-1:0];
    endfunction

    // Queue the whole product in column-major order
    function automatic void queue_product();
        t_product_elem elem;
        for (int col = 0; col < DIM; col++) begin
            for (int row = 0; row < DIM; row++) begin
                elem.index   = INDEX_W'(col * DIM + row);
                elem.value   = dot_product(row, col);
                elem.is_last = (col * DIM + row == CELLS - 1);
                pending_products.push_back(elem);
            end
        end
    endfunction

    function automatic logic signed [DATA_W-1:0] random_cell_value();
        logic [DATA_W-1:0] r;
        case ($urandom_range(9))
            0, 1, 2, 3: begin
                // roughly +/- 8.0, products stay in range
                r = $urandom_range(32'h000F_FFFF);
                return $signed(r - 32'h0008_0000);
            end
            4: begin
                // tiny fractions exercise rounding
                r = $urandom_range(32'h0000_FFFF);
                return $signed(r - 32'h0000_8000);
            end
            5, 6, 7: return $signed(32'($urandom));
            8:       return $urandom_range(1) ? Q_MAX : Q_MIN;
            default: return $urandom_range(1) ? Q_ONE : -Q_ONE;
        endcase
    endfunction

    // Track accepted command transactions in the shadow model
    always @(posedge i_clk) begin
        if (i_rst_n && cmd_if.valid && cmd_if.ready) begin
            case (cmd_if.op)
                OP_LOAD_L: begin
                    if (int'(cmd_if.elem_index) < CELLS) begin
                        left_cells[cmd_if.elem_index] = cmd_if.elem_value;
                    end
                    loads_seen++;
                end
                OP_LOAD_R: begin
                    if (int'(cmd_if.elem_index) < CELLS) begin
                        right_cells[cmd_if.elem_index] = cmd_if.elem_value;
                    end
                    loads_seen++;
                end
                OP_COMPUTE: begin
                    queue_product();
                    computes_seen++;
                end
                default: ignored_seen++;
            endcase
        end
    end

    // Random backpressure on the result channel
    always @(posedge i_clk) begin
        res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Compare each result transaction against the oldest pending element
    always @(posedge i_clk) begin : check_results
        t_product_elem want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_products.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("Unexpected product element: index %0d value %h last %0b",
                             res_if.out_index, res_if.out_value, res_if.last);
                end
            end else begin
                want = pending_products.pop_front();
                products_checked++;
                if (res_if.out_index !== want.index || res_if.out_value !== want.value ||
                    res_if.last !== want.is_last) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("Product mismatch: want index %0d value %h last %0b, got %0d %h %0b",
                                 want.index, want.value, want.is_last,
                                 res_if.out_index, res_if.out_value, res_if.last);
                    end
                end
            end
        end
    end

    // Send one command transaction, with random idle cycles ahead of it
    task automatic send_command(input logic [OP_W-1:0] op, input logic [INDEX_W-1:0] idx,
                                input logic signed [DATA_W-1:0] value);
        if ($urandom_range(99) < send_idle_pct) begin
            cmd_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        cmd_if.valid      <= 1'b1;
        cmd_if.op         <= op;
        cmd_if.elem_index <= idx;
        cmd_if.elem_value <= value;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
    endtask

    // Hold the sender until every pending product element has come back
    task automatic drain_products();
        cmd_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_products.size() != 0) @(posedge i_clk);
    endtask

    // Load a full matrix: identity now and then, otherwise random cells
    task automatic load_matrix(input logic [OP_W-1:0] op);
        bit identity;
        identity = ($urandom_range(3) == 0);
        for (int i = 0; i < CELLS; i++) begin
            if (identity) begin
                send_command(op, INDEX_W'(i), (i % (DIM + 1) == 0) ? Q_ONE : '0);
            end else begin
                send_command(op, INDEX_W'(i), random_cell_value());
            end
        end
    endtask

    // Product straight after reset must be all zeros
    task automatic test_reset_state();
        send_command(OP_COMPUTE, '0, '0);
    endtask

    // Positive and negative saturation of one element
    task automatic test_saturation();
        send_command(OP_LOAD_L, 4'd0, Q_MAX);
        send_command(OP_LOAD_R, 4'd0, Q_MAX);
        send_command(OP_COMPUTE, 4'd15, Q_MIN);
        send_command(OP_LOAD_R, 4'd0, Q_MIN);
        send_command(OP_COMPUTE, 4'd0, Q_MAX);
    endtask

    // Exact half rounds up, just below half rounds down, negative half to zero
    task automatic test_rounding();
        send_command(OP_LOAD_L, 4'd15, 32'sd1);
        send_command(OP_LOAD_R, 4'd15, Q_HALF);
        send_command(OP_COMPUTE, '0, '0);
        send_command(OP_LOAD_R, 4'd15, Q_HALF - 32'sd1);
        send_command(OP_COMPUTE, '0, '0);
        send_command(OP_LOAD_L, 4'd15, -32'sd1);
        send_command(OP_LOAD_R, 4'd15, Q_HALF);
        send_command(OP_COMPUTE, '0, '0);
    endtask

    // Unused op must leave the stores alone; compute ignores index and value
    task automatic test_ignored_ops();
        send_command(OP_UNUSED, 4'd0, '0);
        send_command(OP_UNUSED, 4'd15, 32'shFFFF_FFFF);
        drain_products();
        send_command(OP_COMPUTE, 4'd15, 32'shFFFF_FFFF);
        send_command(OP_COMPUTE, 4'd5, 32'sh5A5A_A5A5);
    endtask

    // Mostly well-formed load/compute sequences, some noise, some drains
    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int item_goal);
        int sent;
        int n;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        while (sent < item_goal) begin
            case ($urandom_range(9))
                0, 1: begin
                    // fresh pair of matrices
                    load_matrix(OP_LOAD_L);
                    load_matrix(OP_LOAD_R);
                    send_command(OP_COMPUTE, INDEX_W'($urandom), random_cell_value());
                    sent += 2 * CELLS + 1;
                end
                2, 3, 4, 5, 6: begin
                    // touch a few cells, then compute
                    n = $urandom_range(1, 6);
                    repeat (n) begin
                        send_command($urandom_range(1) ? OP_LOAD_R : OP_LOAD_L,
                                     INDEX_W'($urandom), random_cell_value());
                    end
                    send_command(OP_COMPUTE, INDEX_W'($urandom), random_cell_value());
                    sent += n + 1;
                end
                7: begin
                    // noise: unused op and a stray load
                    send_command(OP_UNUSED, INDEX_W'($urandom), 32'($urandom));
                    send_command($urandom_range(1) ? OP_LOAD_R : OP_LOAD_L,
                                 INDEX_W'($urandom), 32'($urandom));
                    sent += 2;
                end
                8: begin
                    // back-to-back product requests
                    send_command(OP_COMPUTE, INDEX_W'($urandom), 32'($urandom));
                    send_command(OP_COMPUTE, INDEX_W'($urandom), 32'($urandom));
                    sent += 2;
                end
                default: begin
                    drain_products();
                    send_command(OP_COMPUTE, INDEX_W'($urandom), 32'($urandom));
                    sent += 1;
                end
            endcase
        end
    endtask

    initial begin : main_sequence
        int wait_cycles;
        i_rst_n           = 1'b0;
        cmd_if.valid      = 1'b0;
        cmd_if.op         = OP_LOAD_L;
        cmd_if.elem_index = '0;
        cmd_if.elem_value = '0;
        res_if.ready      = 1'b0;
        send_idle_pct     = 22;
        recv_idle_pct     = 57;
        loads_seen        = 0;
        computes_seen     = 0;
        ignored_seen      = 0;
        products_checked  = 0;
        mismatch_count    = 0;
        for (int i = 0; i < CELLS; i++) begin
            left_cells[i]  = '0;
            right_cells[i] = '0;
        end

        // Hold reset, then release
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_saturation();
        test_rounding();
        test_ignored_ops();
        test_random_traffic(22, 57, 136);
        test_random_traffic(57, 22, 136);
        test_random_traffic(0, 0, 136);

        // Wait for the last products, then give the block time to misbehave
        cmd_if.valid <= 1'b0;
        @(posedge i_clk);
        wait_cycles = 0;
        while (pending_products.size() != 0 && wait_cycles < 20000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (150) @(posedge i_clk);
        if (pending_products.size() != 0) begin
            $display("%0d product elements never arrived", pending_products.size());
            mismatch_count += pending_products.size();
        end

        $display("Run covered %0d loads, %0d product requests, %0d unused-op commands",
                 loads_seen, computes_seen, ignored_seen);
        $display("Checked %0d product elements, %0d failures", products_checked,
                 mismatch_count);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/mmx_pkg.sv
rtl/mmx_in_if.sv
rtl/mmx_out_if.sv
rtl/mmx_ctrl.sv
rtl/mmx_dp.sv
rtl/matrix_multiply_4x4.sv
test/matrix_multiply_4x4_tb.sv
